>>> hdl/crc16ce_pkg.sv
// Shared types, register codes and bit-reversal helpers for the CRC-16 engine.
package crc16ce_pkg;

  localparam int unsigned CrcW  = 16;
  localparam int unsigned ByteW = 8;
  localparam int unsigned AddrW = 3;

  localparam logic [CrcW-1:0] PolyReset = 16'h1021;
  localparam logic [CrcW-1:0] InitReset = 16'h0000;
  localparam logic [CrcW-1:0] XorReset  = 16'h0000;

  typedef enum logic [AddrW-1:0] {
    REG_POLY        = 3'd0,
    REG_INIT        = 3'd1,
    REG_REFLECT_IN  = 3'd2,
    REG_REFLECT_OUT = 3'd3,
    REG_XOR_OUT     = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [CrcW-1:0] poly;
    logic [CrcW-1:0] init;
    logic            refl_in;
    logic            refl_out;
    logic [CrcW-1:0] xor_out;
  } cfg_t;

  function automatic logic [ByteW-1:0] flip8(input logic [ByteW-1:0] v);
    logic [ByteW-1:0] r;
    for (int i = 0; i < ByteW; i++) begin
      r[i] = v[ByteW-1-i];
    end
    return r;
  endfunction

  function automatic logic [CrcW-1:0] flip16(input logic [CrcW-1:0] v);
    logic [CrcW-1:0] r;
    for (int i = 0; i < CrcW; i++) begin
      r[i] = v[CrcW-1-i];
    end
    return r;
  endfunction

endpackage

>>> hdl/crc16_configurable_engine.sv
// Top level: CRC-16 engine with configurable polynomial, init, reflection and output mask.
// A byte is registered in the input register on acceptance and folds from there; a last
//   byte waits while the result register is occupied, then its result is registered there.
// Throughput: one byte per cycle (the byte fold is combinational) unless a last byte waits on the result.
// Reset (rst_n low, synchronous): both stages empty, registers at their reset values
//   (polynomial 0x1021, everything else zero), remainder loaded with zero.
module crc16_configurable_engine (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // last_byte
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [15:0] crc_value, [31:16] raw_remainder
  // configuration write port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);
  import crc16ce_pkg::*;

  cfg_t            cfg;
  logic            init_load;

  // Input register: holds one accepted transaction until it folds.
  logic             in_vld_r;
  logic [ByteW-1:0] byte_r;
  logic             last_r;

  // Running remainder.
  logic [CrcW-1:0]  rem_r, rem_nxt;

  // Result register.
  logic             out_vld_r;
  logic [CrcW-1:0]  crc_r;
  logic [CrcW-1:0]  raw_r;

  logic [CrcW-1:0]  fold_rem;
  logic [CrcW-1:0]  fold_crc;
  logic             fold_go;
  logic             res_load;
  logic             in_acc;

  crc16ce_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .cfg_o       (cfg),
    .init_load_o (init_load)
  );

  crc16ce_fold u_fold (
    .cfg_i  (cfg),
    .rem_i  (rem_r),
    .byte_i (byte_r),
    .rem_o  (fold_rem),
    .crc_o  (fold_crc)
  );

  // Fold the held byte unless it is a last byte and the result slot is still occupied.
  assign fold_go  = in_vld_r && (!last_r || !out_vld_r || out_tready);
  assign res_load = fold_go && last_r;
  assign in_tready = !in_vld_r || fold_go;
  assign in_acc    = in_tvalid && in_tready;

  // Advance the remainder; reload the init value after a last byte or on an init write.
  always_comb begin
    rem_nxt = rem_r;
    if (init_load) begin
      rem_nxt = cfg_wdata;
    end else if (fold_go) begin
      rem_nxt = last_r ? cfg.init : fold_rem;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      rem_r     <= InitReset;
    end else begin
      rem_r <= rem_nxt;
      if (in_acc) begin
        in_vld_r <= 1'b1;
      end else if (fold_go) begin
        in_vld_r <= 1'b0;
      end
      if (res_load) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Payload registers: capture without reset.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      byte_r <= in_tdata;
      last_r <= in_tlast;
    end
    if (res_load) begin
      crc_r <= fold_crc;
      raw_r <= fold_rem;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {raw_r, crc_r};

endmodule

>>> hdl/crc16ce_cfg.sv
// Configuration register file for the CRC-16 engine.
module crc16ce_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [crc16ce_pkg::AddrW-1:0] cfg_addr,
  input  logic [crc16ce_pkg::CrcW-1:0]  cfg_wdata,
  output crc16ce_pkg::cfg_t          cfg_o,
  output logic                       init_load_o
);
  import crc16ce_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt     = cfg_r;
    init_load_o = 1'b0;
    if (cfg_we) begin
      case (cfg_addr)
        REG_POLY:        cfg_nxt.poly     = cfg_wdata;
        REG_INIT: begin
          cfg_nxt.init = cfg_wdata;
          init_load_o  = 1'b1;
        end
        REG_REFLECT_IN:  cfg_nxt.refl_in  = cfg_wdata[0];
        REG_REFLECT_OUT: cfg_nxt.refl_out = cfg_wdata[0];
        REG_XOR_OUT:     cfg_nxt.xor_out  = cfg_wdata;
        default:         cfg_nxt = cfg_r;  // unmapped index: drop the write
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.poly     <= PolyReset;
      cfg_r.init     <= InitReset;
      cfg_r.refl_in  <= 1'b0;
      cfg_r.refl_out <= 1'b0;
      cfg_r.xor_out  <= XorReset;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_o = cfg_r;

endmodule

>>> hdl/crc16ce_fold.sv
// Byte-wide CRC-16 fold (eight unrolled shift steps) and final CRC formatting.
module crc16ce_fold (
  input  crc16ce_pkg::cfg_t              cfg_i,
  input  logic [crc16ce_pkg::CrcW-1:0]   rem_i,
  input  logic [crc16ce_pkg::ByteW-1:0]  byte_i,
  output logic [crc16ce_pkg::CrcW-1:0]   rem_o,
  output logic [crc16ce_pkg::CrcW-1:0]   crc_o
);
  import crc16ce_pkg::*;

  logic [ByteW-1:0] byte_in;
  logic [CrcW-1:0]  acc;

  always_comb begin
    byte_in = cfg_i.refl_in ? flip8(byte_i) : byte_i;
    acc     = rem_i ^ {byte_in, {(CrcW-ByteW){1'b0}}};
    for (int b = 0; b < ByteW; b++) begin
      acc = acc[CrcW-1] ? ({acc[CrcW-2:0], 1'b0} ^ cfg_i.poly) : {acc[CrcW-2:0], 1'b0};
    end
    rem_o = acc;
    crc_o = (cfg_i.refl_out ? flip16(acc) : acc) ^ cfg_i.xor_out;
  end

endmodule

>>> test/tb_top.sv
// Self-checking testbench for the configurable CRC-16 engine: directed vectors, then random traffic.
import crc16ce_pkg::*;

// One expected result, laid out as on out_tdata (crc_value in the low half).
typedef struct packed {
  logic [CrcW-1:0] raw;
  logic [CrcW-1:0] crc;
} crc_result_t;

// Tracks the engine's registers and running remainder, and queues the CRC
// expected at the end of each message.
class crc_scoreboard;
  logic [CrcW-1:0] poly;
  logic [CrcW-1:0] init;
  logic            refl_in;
  logic            refl_out;
  logic [CrcW-1:0] xor_mask;
  logic [CrcW-1:0] remainder;
  crc_result_t     awaited[$];
  int              errors;

  function new();
    poly      = PolyReset;
    init      = InitReset;
    refl_in   = 1'b0;
    refl_out  = 1'b0;
    xor_mask  = XorReset;
    remainder = InitReset;
    errors    = 0;
  endfunction

  // Mirror a register write; index out of range is ignored, wide values are trimmed.
  function void note_cfg(logic [AddrW-1:0] idx, logic [CrcW-1:0] val);
    case (idx)
      REG_POLY:        poly = val;
      REG_INIT: begin
        init      = val;
        remainder = val;
      end
      REG_REFLECT_IN:  refl_in = val[0];
      REG_REFLECT_OUT: refl_out = val[0];
      REG_XOR_OUT:     xor_mask = val;
      default: ;
    endcase
  endfunction

  // Fold one accepted byte; on the last byte of a message queue the result.
  function void note_byte(logic [ByteW-1:0] data, logic last);
    logic [ByteW-1:0] b;
    logic [CrcW-1:0]  r;
    logic [CrcW-1:0]  fin;
    b = data;
    if (refl_in) begin
      for (int i = 0; i < ByteW; i++) b[i] = data[ByteW-1-i];
    end
    r = remainder ^ {b, 8'h00};
    repeat (8) r = r[CrcW-1] ? ((r << 1) ^ poly) : (r << 1);
    if (!last) begin
      remainder = r;
      return;
    end
    fin = r;
    if (refl_out) begin
      for (int i = 0; i < CrcW; i++) fin[i] = r[CrcW-1-i];
    end
    awaited.push_back('{raw: r, crc: fin ^ xor_mask});
    remainder = init;
  endfunction

  function void check_result(logic [2*CrcW-1:0] actual);
    crc_result_t want;
    if (awaited.size() == 0) begin
      $error("unexpected result: crc_value %h raw_remainder %h",
             actual[CrcW-1:0], actual[2*CrcW-1:CrcW]);
      errors++;
      return;
    end
    want = awaited.pop_front();
    if (actual[CrcW-1:0] !== want.crc) begin
      $error("crc_value mismatch: expected %h actual %h", want.crc, actual[CrcW-1:0]);
      errors++;
    end
    if (actual[2*CrcW-1:CrcW] !== want.raw) begin
      $error("raw_remainder mismatch: expected %h actual %h",
             want.raw, actual[2*CrcW-1:CrcW]);
      errors++;
    end
  endfunction
endclass

module tb_top;

  // First index past the register file; writes from here up must be ignored.
  localparam int unsigned RegSpan = 5;
  localparam int unsigned AddrTop = (1 << AddrW) - 1;
  // Cycles for a byte in flight to clear both pipeline stages, with margin.
  localparam int unsigned DrainCycles = 6;
  localparam int unsigned RandPhases  = 12;
  localparam int unsigned PhaseItems  = 54;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        cfg_we     = 1'b0;
  logic [2:0]  cfg_addr   = '0;
  logic [15:0] cfg_wdata  = '0;

  // Random stalls on both sides while set; cleared for the middle random phase and the final stretch.
  bit idle_on = 1'b1;

  crc_scoreboard crc_sb = new();

  crc16_configurable_engine dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Hard stop in case the engine hangs; far beyond the slowest correct run.
  initial begin
    #3000000;
    $display("status: fail");
    $finish;
  end

  // Check every result transaction against the oldest expectation. Sampling
  // at the edge sees pre-edge values, so no ordering race with the engine.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) crc_sb.check_result(out_tdata);
  end

  // Result-side backpressure: random low bursts between random ready
  // stretches; hold ready high whenever idling is off.
  initial begin
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 2) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
  end

  // Write one register; the engine takes it at the edge where cfg_we is high.
  task automatic cfg_write(input logic [AddrW-1:0] idx, input logic [CrcW-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    crc_sb.note_cfg(idx, val);
    cfg_we    <= 1'b0;
  endtask

  // Offer one byte, with an optional random gap first, and hold it until the
  // transaction completes. Leave tvalid high so back-to-back bytes stream.
  task automatic send_byte(input logic [ByteW-1:0] data, input logic last);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    crc_sb.note_byte(data, last);
  endtask

  // Drop tvalid and wait until the engine is idle: all results out and any
  // non-last byte folded, so register writes land between transactions.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (crc_sb.awaited.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Half the time an extreme, otherwise a random 16-bit value.
  function automatic logic [CrcW-1:0] pick16();
    case ($urandom_range(0, 3))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return CrcW'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  // Random register set for one phase; reflect registers get full-width data
  // to exercise trimming, and now and then an out-of-range index is hit.
  task automatic random_config(input int unsigned ph);
    logic [CrcW-1:0] poly_val;
    poly_val = (ph == 0) ? 16'h0000 : (ph == 1) ? 16'hFFFF : pick16();
    if (ph < 2 || $urandom_range(0, 2) != 0) cfg_write(REG_POLY, poly_val);
    if ($urandom_range(0, 2) != 0) cfg_write(REG_INIT, pick16());
    if ($urandom_range(0, 2) != 0) cfg_write(REG_REFLECT_IN, CrcW'($urandom_range(0, 16'hFFFF)));
    if ($urandom_range(0, 2) != 0) cfg_write(REG_REFLECT_OUT, CrcW'($urandom_range(0, 16'hFFFF)));
    if ($urandom_range(0, 2) != 0) cfg_write(REG_XOR_OUT, pick16());
    if ($urandom_range(0, 2) == 0) begin
      cfg_write(AddrW'($urandom_range(RegSpan, AddrTop)), pick16());
    end
  endtask

  // Random phase: well-formed messages of random length and content, a few
  // cut short so they run into the next one, and maybe a partial tail left
  // open for the next register writes to hit.
  task automatic random_traffic(input int unsigned n_items);
    int unsigned sent;
    int unsigned len;
    bit          cut;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 32) : $urandom_range(1, 8);
      cut = ($urandom_range(0, 7) == 0);
      for (int unsigned i = 0; i < len && sent < n_items; i++) begin
        send_byte(ByteW'($urandom_range(0, 255)), !cut && (i == len - 1));
        sent++;
      end
    end
    if ($urandom_range(0, 2) == 0) begin
      repeat ($urandom_range(1, 3)) send_byte(ByteW'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  initial begin
    // Hold reset low at the start, then release it for good.
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: the check string, then single-byte messages at the
    // byte extremes and single set bits.
    for (int i = 0; i < 9; i++) send_byte(8'h31 + ByteW'(i), i == 8);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h80, 1'b1);
    send_byte(8'h01, 1'b1);
    // Leave a message partly folded; the init write below must discard it.
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'hC3, 1'b0);
    drain();

    // Reflected setup with all-ones init and mask; reflect_in gets a value
    // wider than one bit, and an out-of-range index must change nothing.
    cfg_write(REG_INIT, 16'hFFFF);
    cfg_write(REG_POLY, 16'h8005);
    cfg_write(REG_REFLECT_IN, 16'h0003);
    cfg_write(REG_REFLECT_OUT, 16'h0001);
    cfg_write(REG_XOR_OUT, 16'hFFFF);
    cfg_write(AddrW'(RegSpan), 16'h0000);
    for (int i = 0; i < 9; i++) send_byte(8'h31 + ByteW'(i), i == 8);
    // A partial message left open, then a polynomial change mid-message.
    send_byte(8'h3C, 1'b0);
    drain();
    cfg_write(REG_POLY, 16'h1021);
    send_byte(8'hE7, 1'b1);
    drain();

    // Random phases; one in the middle and the last two run without stalls.
    for (int unsigned ph = 0; ph < RandPhases; ph++) begin
      idle_on = !(ph == RandPhases / 2 || ph >= RandPhases - 2);
      random_config(ph);
      random_traffic(PhaseItems);
      drain();
    end

    if (crc_sb.errors == 0 && crc_sb.awaited.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
